// ===== rtl/core/bfgl_pkg.sv =====
package bfgl_pkg;

  localparam int COORD_BITS_DEF = 24;
  localparam int FRAC_BITS_DEF  = 8;

  localparam int SCALE_W   = 16;
  localparam int LHEIGHT_W = 20;
  localparam int WRAP_W    = 23;
  localparam int MISS_W    = 20;
  localparam int CFG_W     = 23;
  localparam int CFG_IDX_W = 2;

  localparam int PIX_W  = 10;
  localparam int ATL_W  = 12;
  localparam int PAGE_W = 4;

  localparam logic [SCALE_W-1:0]   SCALE_RST   = 16'd256;
  localparam logic [LHEIGHT_W-1:0] LHEIGHT_RST = 20'd4096;
  localparam logic [WRAP_W-1:0]    WRAP_RST    = 23'd0;
  localparam logic [MISS_W-1:0]    MISS_RST    = 20'd4096;

  typedef enum logic [1:0] {
    MODE_CR      = 2'd0,
    MODE_NL      = 2'd1,
    MODE_GLYPH   = 2'd2,
    MODE_MISSING = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GLYPH_SCALE     = 2'd0,
    CFG_LINE_HEIGHT     = 2'd1,
    CFG_WRAP_LIMIT      = 2'd2,
    CFG_MISSING_ADVANCE = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    mode_t mode;
    logic  last;
  } ctl_t;

  typedef struct packed {
    logic [ATL_W-1:0]  u0;
    logic [ATL_W-1:0]  v0;
    logic [ATL_W:0]    u1;
    logic [ATL_W:0]    v1;
    logic [PAGE_W-1:0] page;
  } tex_t;

  // width of a scaled pixel count: signed 11 x 17 product, plus any left shift
  function automatic int scl_width(input int frac_bits);
    return 27 + ((frac_bits > 8) ? frac_bits - 8 : 0);
  endfunction

endpackage

// ===== rtl/core/bfgl_if.sv =====
interface bfgl_in_if;
  import bfgl_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic [PIX_W-1:0]  glyph_advance;
  logic signed [PIX_W-1:0] glyph_offset_x;
  logic signed [PIX_W-1:0] glyph_offset_y;
  logic [PIX_W-1:0]  glyph_width;
  logic [PIX_W-1:0]  glyph_height;
  logic [ATL_W-1:0]  atlas_x;
  logic [ATL_W-1:0]  atlas_y;
  logic [PAGE_W-1:0] atlas_page;
  logic              last_char;

  modport source (
    output valid, mode, glyph_advance, glyph_offset_x, glyph_offset_y, glyph_width,
           glyph_height, atlas_x, atlas_y, atlas_page, last_char,
    input  ready
  );

  modport sink (
    input  valid, mode, glyph_advance, glyph_offset_x, glyph_offset_y, glyph_width,
           glyph_height, atlas_x, atlas_y, atlas_page, last_char,
    output ready
  );
endinterface

interface bfgl_out_if #(parameter int COORD_BITS = 24);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] quad_left;
  logic signed [COORD_BITS-1:0] quad_top;
  logic [COORD_BITS-2:0]        quad_width;
  logic [COORD_BITS-2:0]        quad_height;
  logic [11:0]                  tex_u0;
  logic [11:0]                  tex_v0;
  logic [12:0]                  tex_u1;
  logic [12:0]                  tex_v1;
  logic [3:0]                   tex_page;
  logic                         quad_valid;
  logic                         text_end;
  logic signed [COORD_BITS-1:0] text_width;

  modport source (
    output valid, quad_left, quad_top, quad_width, quad_height, tex_u0, tex_v0, tex_u1,
           tex_v1, tex_page, quad_valid, text_end, text_width,
    input  ready
  );

  modport sink (
    input  valid, quad_left, quad_top, quad_width, quad_height, tex_u0, tex_v0, tex_u1,
           tex_v1, tex_page, quad_valid, text_end, text_width,
    output ready
  );
endinterface

// ===== rtl/core/bitmap_font_glyph_layout_core.sv =====
// Bitmap-font glyph layout: one character in, at most one quad out.
// in_chan carries one character per beat: mode (carriage return, newline,
// glyph present, glyph missing), unscaled glyph metrics and atlas rectangle,
// and last_char on the final character of a text.
// out_chan carries one beat per present glyph and one for the last character
// (the same beat when the last character is a glyph): scaled quad, texture
// rectangle, and on the last character the final pen x as text_width.
// Characters that are neither a glyph nor last give no beat.
// cfg_we/cfg_index/cfg_wdata write glyph_scale, line_height, wrap_limit and
// missing_advance; write only while no character is in flight.
// Each input beat passes the scaling multipliers stage, then the pen update
// stage, before its result beat. Throughput: one character per cycle while
// out_chan is not stalled, set by the pen update loop.
// Reset (rst_n low, synchronous) clears the pen, empties both stages and
// restores the register defaults.
// A stalled out_chan holds its beat; the block keeps taking characters until
// both its stages are full, then drops in_chan.ready.
module bitmap_font_glyph_layout_core
  import bfgl_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  bfgl_in_if.sink              in_chan,
  bfgl_out_if.source           out_chan,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int SCL_W = scl_width(FRAC_BITS);

  logic [SCALE_W-1:0]   glyph_scale_r;
  logic [LHEIGHT_W-1:0] line_height_r;
  logic [WRAP_W-1:0]    wrap_limit_r;
  logic [MISS_W-1:0]    missing_advance_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glyph_scale_r     <= SCALE_RST;
      line_height_r     <= LHEIGHT_RST;
      wrap_limit_r      <= WRAP_RST;
      missing_advance_r <= MISS_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_GLYPH_SCALE:     glyph_scale_r     <= cfg_wdata[SCALE_W-1:0];
        CFG_LINE_HEIGHT:     line_height_r     <= cfg_wdata[LHEIGHT_W-1:0];
        CFG_WRAP_LIMIT:      wrap_limit_r      <= cfg_wdata[WRAP_W-1:0];
        CFG_MISSING_ADVANCE: missing_advance_r <= cfg_wdata[MISS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  logic                    s1_valid, s1_ready;
  ctl_t                    s1_ctl;
  tex_t                    s1_tex, o_tex;
  logic signed [SCL_W-1:0] s1_cw, s1_offx, s1_offy, s1_w, s1_h;

  bfgl_scale #(
    .FRAC_BITS (FRAC_BITS),
    .SCL_W     (SCL_W)
  ) u_scale (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_chan.valid),
    .in_ready       (in_chan.ready),
    .mode           (in_chan.mode),
    .glyph_advance  (in_chan.glyph_advance),
    .glyph_offset_x (in_chan.glyph_offset_x),
    .glyph_offset_y (in_chan.glyph_offset_y),
    .glyph_width    (in_chan.glyph_width),
    .glyph_height   (in_chan.glyph_height),
    .atlas_x        (in_chan.atlas_x),
    .atlas_y        (in_chan.atlas_y),
    .atlas_page     (in_chan.atlas_page),
    .last_char      (in_chan.last_char),
    .glyph_scale    (glyph_scale_r),
    .s1_valid       (s1_valid),
    .s1_ready       (s1_ready),
    .s1_ctl         (s1_ctl),
    .s1_tex         (s1_tex),
    .s1_cw          (s1_cw),
    .s1_offx        (s1_offx),
    .s1_offy        (s1_offy),
    .s1_w           (s1_w),
    .s1_h           (s1_h)
  );

  bfgl_pen #(
    .COORD_BITS (COORD_BITS),
    .SCL_W      (SCL_W)
  ) u_pen (
    .clk             (clk),
    .rst_n           (rst_n),
    .s1_valid        (s1_valid),
    .s1_ready        (s1_ready),
    .s1_ctl          (s1_ctl),
    .s1_tex          (s1_tex),
    .s1_cw           (s1_cw),
    .s1_offx         (s1_offx),
    .s1_offy         (s1_offy),
    .s1_w            (s1_w),
    .s1_h            (s1_h),
    .line_height     (line_height_r),
    .wrap_limit      (wrap_limit_r),
    .missing_advance (missing_advance_r),
    .out_valid       (out_chan.valid),
    .out_ready       (out_chan.ready),
    .quad_left       (out_chan.quad_left),
    .quad_top        (out_chan.quad_top),
    .quad_width      (out_chan.quad_width),
    .quad_height     (out_chan.quad_height),
    .tex             (o_tex),
    .quad_valid      (out_chan.quad_valid),
    .text_end        (out_chan.text_end),
    .text_width      (out_chan.text_width)
  );

  assign out_chan.tex_u0   = o_tex.u0;
  assign out_chan.tex_v0   = o_tex.v0;
  assign out_chan.tex_u1   = o_tex.u1;
  assign out_chan.tex_v1   = o_tex.v1;
  assign out_chan.tex_page = o_tex.page;

endmodule

// ===== rtl/core/bfgl_scale.sv =====
module bfgl_scale
  import bfgl_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int SCL_W     = scl_width(FRAC_BITS)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              mode,
  input  logic [PIX_W-1:0]        glyph_advance,
  input  logic signed [PIX_W-1:0] glyph_offset_x,
  input  logic signed [PIX_W-1:0] glyph_offset_y,
  input  logic [PIX_W-1:0]        glyph_width,
  input  logic [PIX_W-1:0]        glyph_height,
  input  logic [ATL_W-1:0]        atlas_x,
  input  logic [ATL_W-1:0]        atlas_y,
  input  logic [PAGE_W-1:0]       atlas_page,
  input  logic                    last_char,
  input  logic [SCALE_W-1:0]      glyph_scale,
  output logic                    s1_valid,
  input  logic                    s1_ready,
  output ctl_t                    s1_ctl,
  output tex_t                    s1_tex,
  output logic signed [SCL_W-1:0] s1_cw,
  output logic signed [SCL_W-1:0] s1_offx,
  output logic signed [SCL_W-1:0] s1_offy,
  output logic signed [SCL_W-1:0] s1_w,
  output logic signed [SCL_W-1:0] s1_h
);

  localparam int SHL = (FRAC_BITS > 8) ? FRAC_BITS - 8 : 0;
  localparam int SHR = (FRAC_BITS < 8) ? 8 - FRAC_BITS : 0;

  // n * Q8.8 scale, moved to FRAC_BITS; arithmetic right shift floors
  function automatic logic signed [SCL_W-1:0] scale_px(input logic signed [PIX_W:0] n,
                                                       input logic [SCALE_W-1:0] s);
    logic signed [26:0]      p;
    logic signed [SCL_W-1:0] pe;
    p  = n * $signed({1'b0, s});
    pe = SCL_W'(p);
    return (pe <<< SHL) >>> SHR;
  endfunction

  logic                    v_r;
  ctl_t                    ctl_r;
  tex_t                    tex_r;
  logic signed [SCL_W-1:0] cw_r, offx_r, offy_r, w_r, h_r;
  logic                    fire;

  assign in_ready = !v_r || s1_ready;
  assign fire     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      ctl_r.mode <= mode_t'(mode);
      ctl_r.last <= last_char;
      tex_r.u0   <= atlas_x;
      tex_r.v0   <= atlas_y;
      tex_r.u1   <= {1'b0, atlas_x} + {3'b000, glyph_width};
      tex_r.v1   <= {1'b0, atlas_y} + {3'b000, glyph_height};
      tex_r.page <= atlas_page;
      cw_r       <= scale_px($signed({1'b0, glyph_advance}), glyph_scale);
      offx_r     <= scale_px({glyph_offset_x[PIX_W-1], glyph_offset_x}, glyph_scale);
      offy_r     <= scale_px({glyph_offset_y[PIX_W-1], glyph_offset_y}, glyph_scale);
      w_r        <= scale_px($signed({1'b0, glyph_width}), glyph_scale);
      h_r        <= scale_px($signed({1'b0, glyph_height}), glyph_scale);
    end
  end

  assign s1_valid = v_r;
  assign s1_ctl   = ctl_r;
  assign s1_tex   = tex_r;
  assign s1_cw    = cw_r;
  assign s1_offx  = offx_r;
  assign s1_offy  = offy_r;
  assign s1_w     = w_r;
  assign s1_h     = h_r;

endmodule

// ===== rtl/core/bfgl_pen.sv =====
module bfgl_pen
  import bfgl_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int SCL_W      = scl_width(FRAC_BITS_DEF)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         s1_valid,
  output logic                         s1_ready,
  input  ctl_t                         s1_ctl,
  input  tex_t                         s1_tex,
  input  logic signed [SCL_W-1:0]      s1_cw,
  input  logic signed [SCL_W-1:0]      s1_offx,
  input  logic signed [SCL_W-1:0]      s1_offy,
  input  logic signed [SCL_W-1:0]      s1_w,
  input  logic signed [SCL_W-1:0]      s1_h,
  input  logic [LHEIGHT_W-1:0]         line_height,
  input  logic [WRAP_W-1:0]            wrap_limit,
  input  logic [MISS_W-1:0]            missing_advance,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS-1:0] quad_left,
  output logic signed [COORD_BITS-1:0] quad_top,
  output logic [COORD_BITS-2:0]        quad_width,
  output logic [COORD_BITS-2:0]        quad_height,
  output tex_t                         tex,
  output logic                         quad_valid,
  output logic                         text_end,
  output logic signed [COORD_BITS-1:0] text_width
);

  localparam int ACC_W = ((COORD_BITS > SCL_W) ? COORD_BITS : SCL_W) + 2;

  function automatic logic signed [COORD_BITS-1:0] sat(input logic signed [ACC_W-1:0] v);
    logic fits;
    fits = (v[ACC_W-1:COORD_BITS-1] == {(ACC_W-COORD_BITS+1){v[ACC_W-1]}});
    if (fits) begin
      return $signed(v[COORD_BITS-1:0]);
    end else if (v[ACC_W-1]) begin
      return $signed({1'b1, {(COORD_BITS-1){1'b0}}});
    end else begin
      return $signed({1'b0, {(COORD_BITS-1){1'b1}}});
    end
  endfunction

  logic signed [COORD_BITS-1:0] pen_x_r, pen_y_r, pen_x_nxt, pen_y_nxt;
  logic signed [COORD_BITS-1:0] left_r, top_r, tw_r;
  logic [COORD_BITS-2:0]        w_r, h_r;
  tex_t                         tex_r;
  logic                         out_v_r, quad_r, end_r;

  logic signed [ACC_W-1:0]      px, py, cw, ox, oy, lh, wl, ma;
  logic signed [COORD_BITS-1:0] py_nl, pxw, pyw, left_c, top_c, pxg, ws, hs, px_c, tw_c;
  logic                         wrap, quad_c, emit, advance, take;

  assign advance  = !out_v_r || out_ready;
  assign s1_ready = advance;
  assign take     = s1_valid && advance;

  always_comb begin
    px     = ACC_W'(pen_x_r);
    py     = ACC_W'(pen_y_r);
    cw     = ACC_W'(s1_cw);
    ox     = ACC_W'(s1_offx);
    oy     = ACC_W'(s1_offy);
    lh     = $signed(ACC_W'(line_height));
    wl     = $signed(ACC_W'(wrap_limit));
    ma     = $signed(ACC_W'(missing_advance));
    py_nl  = sat(py - lh);
    wrap   = (wrap_limit != '0) && ((px + cw) > wl);
    pxw    = wrap ? '0 : pen_x_r;
    pyw    = wrap ? py_nl : pen_y_r;
    left_c = sat(ACC_W'(pxw) + ox);
    top_c  = sat(ACC_W'(pyw) - oy);
    pxg    = sat(ACC_W'(pxw) + cw);
    ws     = sat(ACC_W'(s1_w));
    hs     = sat(ACC_W'(s1_h));
    quad_c = 1'b0;
    px_c   = pen_x_r;
    pen_y_nxt = pen_y_r;
    case (s1_ctl.mode)
      MODE_CR: begin
        px_c = pen_x_r;
      end
      MODE_NL: begin
        px_c      = '0;
        pen_y_nxt = py_nl;
      end
      MODE_GLYPH: begin
        px_c      = pxg;
        pen_y_nxt = pyw;
        quad_c    = 1'b1;
      end
      MODE_MISSING: begin
        px_c = sat(px + ma);
      end
      default: begin
        px_c = pen_x_r;
      end
    endcase
    tw_c      = px_c;
    pen_x_nxt = px_c;
    if (s1_ctl.last) begin
      pen_x_nxt = '0;
      pen_y_nxt = '0;
    end
    emit = quad_c || s1_ctl.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_x_r <= '0;
      pen_y_r <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (take) begin
        pen_x_r <= pen_x_nxt;
        pen_y_r <= pen_y_nxt;
      end
      if (advance) begin
        out_v_r <= take && emit;
      end
    end
  end

  // fields without a quad, or width when not last, are forced to zero
  always_ff @(posedge clk) begin
    if (take) begin
      quad_r <= quad_c;
      end_r  <= s1_ctl.last;
      left_r <= quad_c ? left_c : '0;
      top_r  <= quad_c ? top_c : '0;
      w_r    <= quad_c ? ws[COORD_BITS-2:0] : '0;
      h_r    <= quad_c ? hs[COORD_BITS-2:0] : '0;
      tex_r  <= quad_c ? s1_tex : '0;
      tw_r   <= s1_ctl.last ? tw_c : '0;
    end
  end

  assign out_valid   = out_v_r;
  assign quad_left   = left_r;
  assign quad_top    = top_r;
  assign quad_width  = w_r;
  assign quad_height = h_r;
  assign tex         = tex_r;
  assign quad_valid  = quad_r;
  assign text_end    = end_r;
  assign text_width  = tw_r;

  a_beat_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !quad_r |-> end_r)
    else $error("result beat with neither quad nor text end");

  a_pen_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    take && s1_ctl.last |=> pen_x_r == '0 && pen_y_r == '0)
    else $error("pen not cleared after last character");

  a_width_only_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !end_r |-> tw_r == '0)
    else $error("text width set on a non-final beat");

  a_no_quad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !quad_r |-> left_r == '0 && top_r == '0 && w_r == '0 && h_r == '0)
    else $error("quad fields not cleared on a beat without quad");

  a_pen_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !take |=> $stable(pen_x_r) && $stable(pen_y_r))
    else $error("pen moved without a character");

endmodule
